@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the encoder rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define HCE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// expression must never be true outside reset
`define HCE_NEVER(label, clk, rst_n, expr, msg) \
  `HCE_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

@@ rtl/core/hce_pkg.sv @@
// types, constants and gf(64) helpers for the hermitian code encoder
// no dependencies; used by the interfaces and the encoder top level
package hce_pkg;

  localparam int GF_BITS               = 6;
  localparam int GF_ORDER              = 63;
  localparam logic [GF_BITS-1:0] GF_POLY_LOW = 6'h03;
  localparam int X_DEG_MAX             = 8;
  localparam int CURVE_X_EXP           = 9;
  localparam int SUBFIELD_ORDER        = 7;
  localparam int CODE_LENGTH           = 512;
  localparam int POS_BITS              = 9;
  localparam int PT_K_BITS             = 3;
  localparam int DIM_BITS              = 10;
  localparam logic [DIM_BITS-1:0] DIM_RESET = 10'd409;
  localparam int DEFAULT_MESSAGE_DEPTH = 512;
  localparam int A_BITS                = 4;
  localparam logic [PT_K_BITS-1:0] CIDX_ZERO = 3'd7;

  typedef logic [GF_BITS-1:0] gf_t;
  typedef logic [63:0][GF_BITS-1:0] gf_tab_t;
  typedef logic [63:0][PT_K_BITS-1:0] cidx_tab_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DONE
  } hce_state_e;

  // shift-and-add multiply reduced by x^6+x+1
  function automatic gf_t gf_mul(gf_t a, gf_t b);
    gf_t  r;
    logic carry;
    r = '0;
    for (int i = GF_BITS - 1; i >= 0; i--) begin
      carry = r[GF_BITS-1];
      r     = {r[GF_BITS-2:0], 1'b0};
      if (carry) r = r ^ GF_POLY_LOW;
      if (b[i]) r = r ^ a;
    end
    return r;
  endfunction

  // exponent add and subtract modulo 63, operands below 63
  function automatic gf_t add_mod(gf_t a, gf_t b);
    logic [GF_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 7'(GF_ORDER)) s = s - 7'(GF_ORDER);
    return s[GF_BITS-1:0];
  endfunction

  function automatic gf_t sub_mod(gf_t a, gf_t b);
    logic [GF_BITS:0] s;
    s = {1'b0, a} + 7'(GF_ORDER) - {1'b0, b};
    if (s >= 7'(GF_ORDER)) s = s - 7'(GF_ORDER);
    return s[GF_BITS-1:0];
  endfunction

  function automatic gf_tab_t build_exp();
    gf_tab_t t;
    gf_t     v;
    v = 6'd1;
    for (int i = 0; i < 64; i++) begin
      t[i] = v;
      v    = gf_mul(v, 6'd2);
    end
    return t;
  endfunction

  function automatic gf_tab_t build_log();
    gf_tab_t t;
    gf_tab_t e;
    t = '0;
    e = build_exp();
    for (int i = 0; i < GF_ORDER; i++) t[e[i]] = 6'(i);
    return t;
  endfunction

  // index of x^9 within the subfield: log(x) mod 7, or the zero code
  function automatic cidx_tab_t build_cidx();
    cidx_tab_t t;
    gf_tab_t   lg;
    lg   = build_log();
    t[0] = CIDX_ZERO;
    for (int x = 1; x < 64; x++) t[x] = 3'(int'(lg[x]) % SUBFIELD_ORDER);
    return t;
  endfunction

  // the eight roots of y^8+y = x^9 for each subfield value, rising order
  function automatic gf_tab_t build_ytab();
    gf_tab_t t;
    gf_tab_t e;
    gf_t     c;
    gf_t     s;
    int      k;
    t = '0;
    e = build_exp();
    for (int ci = 0; ci < 8; ci++) begin
      c = (ci == int'(CIDX_ZERO)) ? 6'd0 : e[(CURVE_X_EXP * ci) % GF_ORDER];
      k = 0;
      for (int y = 0; y < 64; y++) begin
        s = gf_mul(6'(y), 6'(y));
        s = gf_mul(s, s);
        s = gf_mul(s, s);
        if (((s ^ 6'(y)) == c) && (k < 8)) begin
          t[ci * 8 + k] = 6'(y);
          k = k + 1;
        end
      end
    end
    return t;
  endfunction

  localparam gf_tab_t   GF_EXP    = build_exp();
  localparam gf_tab_t   GF_LOG    = build_log();
  localparam cidx_tab_t CURVE_CIDX = build_cidx();
  localparam gf_tab_t   CURVE_Y   = build_ytab();

endpackage

@@ rtl/core/hce_in_if.sv @@
// input word channel of the encoder: command, position and symbol
// depends on hce_pkg for field widths
interface hce_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [hce_pkg::POS_BITS-1:0]  position;
  logic [hce_pkg::GF_BITS-1:0]   symbol_value;

  modport source (output valid, command, position, symbol_value, input ready);
  modport sink   (input valid, command, position, symbol_value, output ready);
endinterface

@@ rtl/core/hce_out_if.sv @@
// output word channel of the encoder: codeword symbol and its position
// depends on hce_pkg for field widths
interface hce_out_if;
  logic                          valid;
  logic                          ready;
  logic [hce_pkg::GF_BITS-1:0]   codeword_value;
  logic [hce_pkg::POS_BITS-1:0]  codeword_position;

  modport source (output valid, codeword_value, codeword_position, input ready);
  modport sink   (input valid, codeword_value, codeword_position, output ready);
endinterface

@@ rtl/core/hce_cfg_if.sv @@
// configuration write channel of the encoder carrying the code dimension
// depends on hce_pkg for the data width
interface hce_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hce_pkg::DIM_BITS-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/hermitian_code_encoder.sv @@
// hermitian code evaluation encoder over gf(64), top level; depends on hce_pkg,
// hce_in_if, hce_out_if, hce_cfg_if, hce_ram and assert_macros.svh.
// A load word writes one message symbol into the message ram;
// loads are taken even while a finished codeword word still waits at the output.
// An evaluate word looks up its curve point from constant tables, then sums
// min(code_dimension, MESSAGE_DEPTH) terms m_j * x^a_j * y^b_j with a single
// gf multiply-accumulate fed by the one read port of the message ram, one term
// per cycle; input ready stays low from the time the word is accepted until the
// result is handed to the output register. Message entries must be loaded before
// they are summed.
`include "assert_macros.svh"

module hermitian_code_encoder #(
  parameter int MESSAGE_DEPTH = hce_pkg::DEFAULT_MESSAGE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hce_in_if.sink    in_i,
  hce_out_if.source out_o,
  hce_cfg_if.sink   cfg_i
);

  localparam int AW = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
  localparam int JW = $clog2(MESSAGE_DEPTH + 1);

  hce_pkg::hce_state_e state_q, state_d;

  logic [hce_pkg::DIM_BITS-1:0] dim_q;
  logic [hce_pkg::POS_BITS-1:0] pos_q;
  hce_pkg::gf_t x_q, y_q, lx_q, ly_q;
  hce_pkg::gf_t px_q, py_q, dpx_q, dpy_q;
  hce_pkg::gf_t basis_q, acc_q;
  hce_pkg::gf_t out_value_q;
  logic [hce_pkg::POS_BITS-1:0] out_pos_q;
  logic [hce_pkg::A_BITS-1:0] a_cur_q, a_start_q;
  logic [JW-1:0] terms_q, terms_d, j_q;
  logic b_zero_q, issue_v_q, out_valid_q;

  logic accept, load_we, eval_go, issue, fin;
  logic end_deg, grow, basis_zero;
  logic [hce_pkg::A_BITS-1:0] nxt_a_start;
  hce_pkg::gf_t nxt_dpx, nxt_dpy, basis_e, basis_d;
  hce_pkg::gf_t ram_rdata;
  hce_pkg::gf_t pt_x;

  assign in_i.ready  = (state_q == hce_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign load_we     = accept && !in_i.command && (int'(in_i.position) < MESSAGE_DEPTH);
  assign eval_go     = accept && in_i.command;

  assign pt_x = in_i.position[hce_pkg::POS_BITS-1:hce_pkg::PT_K_BITS];

  always_comb begin
    if (int'(dim_q) >= MESSAGE_DEPTH) terms_d = JW'(MESSAGE_DEPTH);
    else terms_d = JW'(dim_q);
  end

  hce_ram #(
    .Width     (hce_pkg::GF_BITS),
    .Depth     (MESSAGE_DEPTH),
    .AddrWidth (AW)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(in_i.position)),
    .wdata_i (in_i.symbol_value),
    .raddr_i (j_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    issue   = 1'b0;
    fin     = 1'b0;
    unique case (state_q)
      hce_pkg::ST_IDLE: begin
        if (eval_go) state_d = hce_pkg::ST_SETUP;
      end
      hce_pkg::ST_SETUP: begin
        state_d = hce_pkg::ST_RUN;
      end
      hce_pkg::ST_RUN: begin
        if (j_q < terms_q) issue = 1'b1;
        else state_d = hce_pkg::ST_DONE;
      end
      hce_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          fin     = 1'b1;
          state_d = hce_pkg::ST_IDLE;
        end
      end
      default: state_d = hce_pkg::ST_IDLE;
    endcase
  end

  // exponent walk in pole-basis order, kept as logs modulo 63
  assign end_deg     = (a_cur_q == '0);
  assign grow        = (a_start_q < hce_pkg::A_BITS'(hce_pkg::X_DEG_MAX));
  assign nxt_a_start = grow ? a_start_q + hce_pkg::A_BITS'(1) : a_start_q;
  assign nxt_dpx     = grow ? hce_pkg::add_mod(dpx_q, lx_q) : dpx_q;
  assign nxt_dpy     = grow ? '0 : hce_pkg::add_mod(dpy_q, ly_q);
  assign basis_e     = hce_pkg::add_mod(px_q, py_q);
  assign basis_zero  = ((x_q == '0) && (a_cur_q != '0)) || ((y_q == '0) && !b_zero_q);
  assign basis_d     = basis_zero ? '0 : hce_pkg::GF_EXP[basis_e];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hce_pkg::ST_IDLE;
      dim_q       <= hce_pkg::DIM_RESET;
      issue_v_q   <= 1'b0;
      out_valid_q <= 1'b0;
      a_cur_q     <= '0;
      a_start_q   <= '0;
    end else begin
      state_q   <= state_d;
      issue_v_q <= issue;
      if (cfg_i.valid) dim_q <= cfg_i.data;
      if (fin) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      if (state_q == hce_pkg::ST_SETUP) begin
        a_cur_q   <= '0;
        a_start_q <= '0;
      end else if (issue) begin
        if (end_deg) begin
          a_start_q <= nxt_a_start;
          a_cur_q   <= nxt_a_start;
        end else begin
          a_cur_q <= a_cur_q - hce_pkg::A_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_go) begin
      pos_q   <= in_i.position;
      x_q     <= pt_x;
      y_q     <= hce_pkg::CURVE_Y[{hce_pkg::CURVE_CIDX[pt_x],
                                   in_i.position[hce_pkg::PT_K_BITS-1:0]}];
      terms_q <= terms_d;
    end
    if (state_q == hce_pkg::ST_SETUP) begin
      lx_q     <= hce_pkg::GF_LOG[x_q];
      ly_q     <= hce_pkg::GF_LOG[y_q];
      j_q      <= '0;
      px_q     <= '0;
      py_q     <= '0;
      dpx_q    <= '0;
      dpy_q    <= '0;
      b_zero_q <= 1'b1;
      acc_q    <= '0;
    end else begin
      if (issue) begin
        j_q     <= j_q + JW'(1);
        basis_q <= basis_d;
        if (end_deg) begin
          dpx_q    <= nxt_dpx;
          px_q     <= nxt_dpx;
          dpy_q    <= nxt_dpy;
          py_q     <= nxt_dpy;
          b_zero_q <= grow;
        end else begin
          px_q     <= hce_pkg::sub_mod(px_q, lx_q);
          py_q     <= hce_pkg::add_mod(py_q, ly_q);
          b_zero_q <= 1'b0;
        end
      end
      if (issue_v_q) acc_q <= acc_q ^ hce_pkg::gf_mul(ram_rdata, basis_q);
    end
    if (fin) begin
      out_value_q <= acc_q;
      out_pos_q   <= pos_q;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.codeword_value    = out_value_q;
  assign out_o.codeword_position = out_pos_q;

  `HCE_ASSERT(a_term_bound, clk_i, rst_ni, (state_q == hce_pkg::ST_RUN) |-> (j_q <= terms_q), "term index past dimension")
  `HCE_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == hce_pkg::ST_DONE), "output word without finished sum")
  `HCE_ASSERT(a_issue_from_run, clk_i, rst_ni, issue_v_q |-> $past(state_q == hce_pkg::ST_RUN), "accumulate outside summing")
  `HCE_NEVER(a_xdeg_bound, clk_i, rst_ni, a_cur_q > hce_pkg::A_BITS'(hce_pkg::X_DEG_MAX), "x degree above limit")

endmodule

@@ rtl/core/hce_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module hce_ram #(
  parameter int Width     = 6,
  parameter int Depth     = 512,
  parameter int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
